// ===== rtl/mou_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mou_pkg
// Shared widths, configuration types and fixed-point helpers for the
// momentum optimizer update pipeline.
// ----------------------------------------------------------------------------
package mou_pkg;

    // value and coefficient formats
    localparam int VAL_W  = 32;               // signed Q16.16
    localparam int COEF_W = 18;               // signed Q2.16
    localparam int FRAC_W = 16;
    localparam int PROD_W = VAL_W + COEF_W;   // exact coefficient * value
    localparam int RND_W  = PROD_W - FRAC_W;  // product rounded back to Q.16
    localparam int SUM_W  = RND_W + 1;        // sum of a rounded product and a value

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOMENTUM_DECAY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRADIENT_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_DECAY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAST_FIRST_STEP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NESTEROV_MODE   = 3'd5;

    // pipeline depth
    localparam int NUM_STG = 8;

    localparam logic signed [VAL_W-1:0]  VAL_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0]  VAL_MIN  = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (FRAC_W - 1);

    // configuration bundle seen by the datapath
    typedef struct packed {
        logic signed [COEF_W-1:0] learning_rate;
        logic signed [COEF_W-1:0] momentum_decay;
        logic signed [COEF_W-1:0] gradient_scale;
        logic signed [COEF_W-1:0] weight_decay;
        logic                     past_first_step;
        logic                     nesterov_mode;
    } t_cfg;

    // round to nearest, ties toward +inf: add one half, arithmetic shift
    function automatic logic signed [RND_W-1:0] rnd_q16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] q;
        q = p + RND_HALF;
        return $signed(q[PROD_W-1:FRAC_W]);
    endfunction

    // sum does not fit the value range
    function automatic logic sum_ovf(input logic signed [SUM_W-1:0] s);
        return (s[SUM_W-1:VAL_W-1] != '0) && (s[SUM_W-1:VAL_W-1] != '1);
    endfunction

    // clip a sum to the value range
    function automatic logic signed [VAL_W-1:0] sum_clip(input logic signed [SUM_W-1:0] s);
        logic signed [VAL_W-1:0] c;
        if (sum_ovf(s)) begin
            c = s[SUM_W-1] ? VAL_MIN : VAL_MAX;
        end else begin
            c = s[VAL_W-1:0];
        end
        return c;
    endfunction

endpackage

// ===== rtl/mou_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mou_datapath
// Eight-stage arithmetic pipeline: multiply stages alternate with round,
// add and clip stages. Each stage loads when its enable is high.
// ----------------------------------------------------------------------------
module mou_datapath
    import mou_pkg::*;
(
    input  logic                      i_clk,
    input  logic [NUM_STG-1:0]        i_en,
    input  t_cfg                      i_cfg,
    input  logic signed [VAL_W-1:0]   i_param_value,
    input  logic signed [VAL_W-1:0]   i_gradient,
    input  logic signed [VAL_W-1:0]   i_velocity,
    output logic signed [VAL_W-1:0]   o_new_param,
    output logic signed [VAL_W-1:0]   o_new_velocity,
    output logic                      o_saturated
);

    // stage 0: weight decay and momentum products
    logic signed [PROD_W-1:0] r0_pwd, r0_pav;
    logic signed [VAL_W-1:0]  r0_x, r0_g;

    // stage 1: regularized gradient
    logic signed [VAL_W-1:0]  r1_greg, r1_x;
    logic signed [RND_W-1:0]  r1_av;
    logic                     r1_sat;

    // stage 2: gradient scale product
    logic signed [PROD_W-1:0] r2_pbg;
    logic signed [VAL_W-1:0]  r2_greg, r2_x;
    logic signed [RND_W-1:0]  r2_av;
    logic                     r2_sat;

    // stage 3: new velocity
    logic signed [VAL_W-1:0]  r3_vnew, r3_greg, r3_x;
    logic                     r3_sat;

    // stage 4: nesterov momentum product
    logic signed [PROD_W-1:0] r4_pavn;
    logic signed [VAL_W-1:0]  r4_vnew, r4_greg, r4_x;
    logic                     r4_sat;

    // stage 5: step direction
    logic signed [VAL_W-1:0]  r5_dir, r5_vnew, r5_x;
    logic                     r5_sat;

    // stage 6: learning rate product
    logic signed [PROD_W-1:0] r6_plr;
    logic signed [VAL_W-1:0]  r6_vnew, r6_x;
    logic                     r6_sat;

    // stage 7: output register
    logic signed [VAL_W-1:0]  r7_xnew, r7_vnew;
    logic                     r7_sat;

    logic signed [SUM_W-1:0]  n1_sum, n3_sum, n5_sum, n7_sum;
    logic signed [RND_W-1:0]  n3_scaled;
    logic                     n5_sat;

    // combinational round, add and clip
    always_comb begin
        n1_sum    = SUM_W'(rnd_q16(r0_pwd)) + SUM_W'(r0_g);
        n3_scaled = r2_sat ? '0 : '0;
        if (i_cfg.past_first_step) begin
            n3_scaled = rnd_q16(r2_pbg);
        end else begin
            n3_scaled = RND_W'(r2_greg);
        end
        n3_sum    = SUM_W'(r2_av) + SUM_W'(n3_scaled);
        n5_sum    = SUM_W'(r4_greg) + SUM_W'(rnd_q16(r4_pavn));
        n5_sat    = i_cfg.nesterov_mode && sum_ovf(n5_sum);
        n7_sum    = SUM_W'(r6_x) - SUM_W'(rnd_q16(r6_plr));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_pwd <= PROD_W'(i_cfg.weight_decay) * PROD_W'(i_param_value);
            r0_pav <= PROD_W'(i_cfg.momentum_decay) * PROD_W'(i_velocity);
            r0_x   <= i_param_value;
            r0_g   <= i_gradient;
        end
        if (i_en[1]) begin
            r1_greg <= sum_clip(n1_sum);
            r1_sat  <= sum_ovf(n1_sum);
            r1_av   <= rnd_q16(r0_pav);
            r1_x    <= r0_x;
        end
        if (i_en[2]) begin
            r2_pbg  <= PROD_W'(i_cfg.gradient_scale) * PROD_W'(r1_greg);
            r2_greg <= r1_greg;
            r2_av   <= r1_av;
            r2_x    <= r1_x;
            r2_sat  <= r1_sat;
        end
        if (i_en[3]) begin
            r3_vnew <= sum_clip(n3_sum);
            r3_sat  <= r2_sat | sum_ovf(n3_sum);
            r3_greg <= r2_greg;
            r3_x    <= r2_x;
        end
        if (i_en[4]) begin
            r4_pavn <= PROD_W'(i_cfg.momentum_decay) * PROD_W'(r3_vnew);
            r4_vnew <= r3_vnew;
            r4_greg <= r3_greg;
            r4_x    <= r3_x;
            r4_sat  <= r3_sat;
        end
        if (i_en[5]) begin
            r5_dir  <= i_cfg.nesterov_mode ? sum_clip(n5_sum) : r4_vnew;
            r5_sat  <= r4_sat | n5_sat;
            r5_vnew <= r4_vnew;
            r5_x    <= r4_x;
        end
        if (i_en[6]) begin
            r6_plr  <= PROD_W'(i_cfg.learning_rate) * PROD_W'(r5_dir);
            r6_vnew <= r5_vnew;
            r6_x    <= r5_x;
            r6_sat  <= r5_sat;
        end
        if (i_en[7]) begin
            r7_xnew <= sum_clip(n7_sum);
            r7_sat  <= r6_sat | sum_ovf(n7_sum);
            r7_vnew <= r6_vnew;
        end
    end

    assign o_new_param    = r7_xnew;
    assign o_new_velocity = r7_vnew;
    assign o_saturated    = r7_sat;

endmodule

// ===== rtl/momentum_optimizer_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// momentum_optimizer_update
// Element-wise SGD step with standard or Nesterov momentum in fixed point.
// ----------------------------------------------------------------------------
// The block takes one element transaction per clock while the output side
// keeps up and returns one result transaction per element, in order. The
// pipeline depth comes from four dependent multiplies (weight decay,
// gradient scale, momentum on the new velocity, learning rate), each
// followed by its own round, add and clip stage. Stages with no valid
// element absorb stalls, so input is still taken while a result waits.
// Write the configuration registers only while no element is in flight.
module momentum_optimizer_update
    import mou_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write port
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [VAL_W-1:0] i_param_value,
    input  logic signed [VAL_W-1:0] i_gradient,
    input  logic signed [VAL_W-1:0] i_velocity,
    // result channel
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [VAL_W-1:0] o_new_param,
    output logic signed [VAL_W-1:0] o_new_velocity,
    output logic                    o_saturated
);

    t_cfg               r_cfg;
    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] w_en;
    logic [NUM_STG-1:0] n_vld;
    logic               w_in_acc;
    logic               w_out_acc;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_LEARNING_RATE:   r_cfg.learning_rate   <= $signed(i_cfg_data);
                REG_MOMENTUM_DECAY:  r_cfg.momentum_decay  <= $signed(i_cfg_data);
                REG_GRADIENT_SCALE:  r_cfg.gradient_scale  <= $signed(i_cfg_data);
                REG_WEIGHT_DECAY:    r_cfg.weight_decay    <= $signed(i_cfg_data);
                REG_PAST_FIRST_STEP: r_cfg.past_first_step <= i_cfg_data[0];
                REG_NESTEROV_MODE:   r_cfg.nesterov_mode   <= i_cfg_data[0];
                default:             r_cfg <= r_cfg;
            endcase
        end
    end

    // stage enables: a stage loads when empty or when the next one moves
    always_comb begin
        w_en[NUM_STG-1] = ~r_vld[NUM_STG-1] | i_ready;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            w_en[k] = ~r_vld[k] | w_en[k+1];
        end
        n_vld[0] = i_valid;
        for (int k = 1; k < NUM_STG; k++) begin
            n_vld[k] = r_vld[k-1];
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_STG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign o_ready   = w_en[0];
    assign o_valid   = r_vld[NUM_STG-1];
    assign w_in_acc  = i_valid & o_ready;
    assign w_out_acc = o_valid & i_ready;

    // arithmetic pipeline
    mou_datapath u_datapath (
        .i_clk          (i_clk),
        .i_en           (w_en),
        .i_cfg          (r_cfg),
        .i_param_value  (i_param_value),
        .i_gradient     (i_gradient),
        .i_velocity     (i_velocity),
        .o_new_param    (o_new_param),
        .o_new_velocity (o_new_velocity),
        .o_saturated    (o_saturated)
    );

    // an empty output stage means no stage can be stalled
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[NUM_STG-1] |-> o_ready)
        else $error("input not ready with empty output stage");

    // a blocked first stage keeps its element
    a_stage0_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && !w_en[1] |=> r_vld[0])
        else $error("stalled element dropped from first stage");

    // elements in flight change only by accepted transactions
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> ($countones(r_vld) == $past($countones(r_vld))
                     + $past(int'(w_in_acc)) - $past(int'(w_out_acc))))
        else $error("element count mismatch in pipeline");

endmodule
